// File: hdl/bdc_pkg.sv
// ----------------------------------------------------------------------------
// bdc_pkg
// Types and constants shared by the button debounce / click classifier.
// ----------------------------------------------------------------------------
`default_nettype none

package bdc_pkg;

    localparam int NOW_W    = 32;
    localparam int OUT_T_W  = 32;
    localparam int CFG_W    = 24;
    localparam int CFG_A_W  = 2;

    // register indexes on the configuration port
    localparam logic [CFG_A_W-1:0] CFG_DEBOUNCE_TIME      = 2'd0;
    localparam logic [CFG_A_W-1:0] CFG_DOUBLE_WINDOW      = 2'd1;
    localparam logic [CFG_A_W-1:0] CFG_LONG_HOLD_TIME     = 2'd2;
    localparam logic [CFG_A_W-1:0] CFG_POWEROFF_HOLD_TIME = 2'd3;

    // request kinds
    localparam logic REQ_POLL    = 1'b0;
    localparam logic REQ_CONSUME = 1'b1;

    localparam logic [15:0] DEBOUNCE_TIME_RST      = 16'd15;
    localparam logic [15:0] DOUBLE_WINDOW_RST      = 16'd400;
    localparam logic [23:0] LONG_HOLD_TIME_RST     = 24'd1000;
    localparam logic [23:0] POWEROFF_HOLD_TIME_RST = 24'd5000;

    typedef struct packed {
        logic [15:0] debounce_time;
        logic [15:0] double_window;
        logic [23:0] long_hold_time;
        logic [23:0] poweroff_hold_time;
    } bdc_cfg_t;

    typedef struct packed {
        logic             req_type;
        logic [NOW_W-1:0] now_ms;
        logic             raw_level;
    } bdc_item_t;

    typedef struct packed {
        logic               short_event;
        logic               double_event;
        logic               long_event;
        logic               poweroff_event;
        logic               is_pressed;
        logic [OUT_T_W-1:0] held_time;
        logic [OUT_T_W-1:0] activity_time;
    } bdc_result_t;

endpackage

`default_nettype wire

// File: hdl/bdc_cfg_regs.sv
// ----------------------------------------------------------------------------
// bdc_cfg_regs
// Configuration register file: write-only, one register per index.
// ----------------------------------------------------------------------------
`default_nettype none

module bdc_cfg_regs (
    input  wire                         aclk,
    input  wire                         aresetn,
    input  wire                         cfg_we,
    input  wire  [bdc_pkg::CFG_A_W-1:0] cfg_addr,
    input  wire  [bdc_pkg::CFG_W-1:0]   cfg_wdata,
    output bdc_pkg::bdc_cfg_t           cfg
);
    import bdc_pkg::*;

    bdc_cfg_t cfg_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cfg_reg.debounce_time      <= DEBOUNCE_TIME_RST;
            cfg_reg.double_window      <= DOUBLE_WINDOW_RST;
            cfg_reg.long_hold_time     <= LONG_HOLD_TIME_RST;
            cfg_reg.poweroff_hold_time <= POWEROFF_HOLD_TIME_RST;
        end else if (cfg_we) begin
            unique case (cfg_addr)
                CFG_DEBOUNCE_TIME:      cfg_reg.debounce_time      <= cfg_wdata[15:0];
                CFG_DOUBLE_WINDOW:      cfg_reg.double_window      <= cfg_wdata[15:0];
                CFG_LONG_HOLD_TIME:     cfg_reg.long_hold_time     <= cfg_wdata[23:0];
                CFG_POWEROFF_HOLD_TIME: cfg_reg.poweroff_hold_time <= cfg_wdata[23:0];
                default: ;
            endcase
        end
    end

    assign cfg = cfg_reg;

endmodule

`default_nettype wire

// File: hdl/bdc_in_stage.sv
// ----------------------------------------------------------------------------
// bdc_in_stage
// Input register: captures one request transaction per cycle while the held item moves on.
// ----------------------------------------------------------------------------
`default_nettype none

module bdc_in_stage (
    input  wire                aclk,
    input  wire                aresetn,
    input  wire                in_valid,
    output logic               in_ready,
    input  bdc_pkg::bdc_item_t in_item,
    output logic               item_valid,
    input  wire                item_take,
    output bdc_pkg::bdc_item_t item
);
    import bdc_pkg::*;

    logic      valid_reg;
    bdc_item_t item_reg;

    // free when empty or when the held item moves on this cycle
    assign in_ready = !valid_reg || item_take;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= 1'b0;
        end else if (in_ready) begin
            valid_reg <= in_valid;
        end
    end

    always_ff @(posedge aclk) begin
        if (in_valid && in_ready) begin
            item_reg <= in_item;
        end
    end

    assign item_valid = valid_reg;
    assign item       = item_reg;

endmodule

`default_nettype wire

// File: hdl/bdc_core.sv
// ----------------------------------------------------------------------------
// bdc_core
// Debounce and press classification state; one update per transaction.
// ----------------------------------------------------------------------------
`default_nettype none

module bdc_core #(
    parameter int TIME_BITS = 32
) (
    input  wire                  aclk,
    input  wire                  aresetn,
    input  bdc_pkg::bdc_cfg_t    cfg,
    input  wire                  fire,
    input  bdc_pkg::bdc_item_t   item,
    output bdc_pkg::bdc_result_t result
);
    import bdc_pkg::*;

    localparam int TW = TIME_BITS;
    // compare width: hold thresholds are up to 24 bits wide
    localparam int CW = (TW > CFG_W) ? TW : CFG_W;

    logic          prev_raw_reg,         prev_raw_next;
    logic [TW-1:0] raw_change_time_reg,  raw_change_time_next;
    logic          pressed_reg,          pressed_next;
    logic [TW-1:0] press_start_time_reg, press_start_time_next;
    logic          click_pending_reg,    click_pending_next;
    logic [TW-1:0] release_time_reg,     release_time_next;
    logic          long_done_reg,        long_done_next;
    logic          poweroff_done_reg,    poweroff_done_next;
    logic          click_supp_reg,       click_supp_next;
    logic          ignore_press_reg,     ignore_press_next;
    logic [TW-1:0] last_activity_reg,    last_activity_next;

    always_comb begin
        logic [TW-1:0] now;
        logic [TW-1:0] el_change;
        logic [TW-1:0] el_release;
        logic [TW-1:0] held;
        logic          level;
        logic          ev_short, ev_double, ev_long, ev_off;

        now                   = TW'(item.now_ms);
        prev_raw_next         = prev_raw_reg;
        raw_change_time_next  = raw_change_time_reg;
        pressed_next          = pressed_reg;
        press_start_time_next = press_start_time_reg;
        click_pending_next    = click_pending_reg;
        release_time_next     = release_time_reg;
        long_done_next        = long_done_reg;
        poweroff_done_next    = poweroff_done_reg;
        click_supp_next       = click_supp_reg;
        ignore_press_next     = ignore_press_reg;
        last_activity_next    = last_activity_reg;
        ev_short  = 1'b0;
        ev_double = 1'b0;
        ev_long   = 1'b0;
        ev_off    = 1'b0;
        el_change  = '0;
        el_release = '0;
        held       = '0;
        level      = pressed_reg;

        if (item.req_type == REQ_CONSUME) begin
            click_pending_next = 1'b0;
            if (pressed_reg) begin
                ignore_press_next = 1'b1;
            end
        end else begin
            if (item.raw_level != prev_raw_reg) begin
                prev_raw_next        = item.raw_level;
                raw_change_time_next = now;
            end
            el_change = now - raw_change_time_next;
            if (CW'(el_change) >= CW'(cfg.debounce_time)) begin
                level = !item.raw_level;
            end

            if (level && !pressed_reg) begin
                pressed_next          = 1'b1;
                press_start_time_next = now;
                long_done_next        = 1'b0;
                poweroff_done_next    = 1'b0;
                click_supp_next       = 1'b0;
                last_activity_next    = now;
            end else if (!level && pressed_reg) begin
                pressed_next       = 1'b0;
                last_activity_next = now;
                if (ignore_press_reg) begin
                    ignore_press_next = 1'b0;
                end else if (!click_supp_reg) begin
                    el_release = now - release_time_reg;
                    if (click_pending_reg &&
                        CW'(el_release) < CW'(cfg.double_window)) begin
                        ev_double          = 1'b1;
                        click_pending_next = 1'b0;
                        release_time_next  = '0;
                    end else begin
                        click_pending_next = 1'b1;
                        release_time_next  = now;
                    end
                end
            end

            if (pressed_next) begin
                last_activity_next = now;
                if (!ignore_press_next) begin
                    held = now - press_start_time_next;
                    if (!long_done_next && CW'(held) >= CW'(cfg.long_hold_time)) begin
                        ev_long            = 1'b1;
                        long_done_next     = 1'b1;
                        click_supp_next    = 1'b1;
                        click_pending_next = 1'b0;
                    end
                    if (!poweroff_done_next &&
                        CW'(held) >= CW'(cfg.poweroff_hold_time)) begin
                        ev_off             = 1'b1;
                        poweroff_done_next = 1'b1;
                    end
                end
            end else begin
                el_release = now - release_time_next;
                if (click_pending_next && CW'(el_release) >= CW'(cfg.double_window)) begin
                    ev_short           = 1'b1;
                    click_pending_next = 1'b0;
                end
            end
        end

        result.short_event    = ev_short;
        result.double_event   = ev_double;
        result.long_event     = ev_long;
        result.poweroff_event = ev_off;
        result.is_pressed     = pressed_next;
        result.held_time      = pressed_next ?
                                OUT_T_W'(TW'(now - press_start_time_next)) : '0;
        result.activity_time  = OUT_T_W'(last_activity_next);
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            prev_raw_reg         <= 1'b1;
            raw_change_time_reg  <= '0;
            pressed_reg          <= 1'b0;
            press_start_time_reg <= '0;
            click_pending_reg    <= 1'b0;
            release_time_reg     <= '0;
            long_done_reg        <= 1'b0;
            poweroff_done_reg    <= 1'b0;
            click_supp_reg       <= 1'b0;
            ignore_press_reg     <= 1'b0;
            last_activity_reg    <= '0;
        end else if (fire) begin
            prev_raw_reg         <= prev_raw_next;
            raw_change_time_reg  <= raw_change_time_next;
            pressed_reg          <= pressed_next;
            press_start_time_reg <= press_start_time_next;
            click_pending_reg    <= click_pending_next;
            release_time_reg     <= release_time_next;
            long_done_reg        <= long_done_next;
            poweroff_done_reg    <= poweroff_done_next;
            click_supp_reg       <= click_supp_next;
            ignore_press_reg     <= ignore_press_next;
            last_activity_reg    <= last_activity_next;
        end
    end

    a_no_short_and_double: assert property (@(posedge aclk) disable iff (!aresetn)
        fire |-> !(result.short_event && result.double_event))
        else $error("short and double event in one transaction");

    a_consume_no_events: assert property (@(posedge aclk) disable iff (!aresetn)
        fire && item.req_type == REQ_CONSUME |->
            !(result.short_event || result.double_event ||
              result.long_event || result.poweroff_event))
        else $error("event reported on a consume transaction");

    a_long_while_pressed: assert property (@(posedge aclk) disable iff (!aresetn)
        fire && result.long_event |=> pressed_reg && long_done_reg && !click_pending_reg)
        else $error("long event left inconsistent press state");

    a_double_clears_pending: assert property (@(posedge aclk) disable iff (!aresetn)
        fire && result.double_event |=> !click_pending_reg && release_time_reg == '0)
        else $error("double event did not clear the pending click");

    a_released_zero_held: assert property (@(posedge aclk) disable iff (!aresetn)
        fire && !result.is_pressed |-> result.held_time == '0)
        else $error("held time nonzero while released");

endmodule

`default_nettype wire

// File: hdl/bdc_out_stage.sv
// ----------------------------------------------------------------------------
// bdc_out_stage
// Result register: holds one result until the downstream side takes it.
// ----------------------------------------------------------------------------
`default_nettype none

module bdc_out_stage (
    input  wire                  aclk,
    input  wire                  aresetn,
    input  wire                  load,
    input  bdc_pkg::bdc_result_t load_result,
    output logic                 can_load,
    output logic                 out_valid,
    input  wire                  out_ready,
    output bdc_pkg::bdc_result_t out_result
);
    import bdc_pkg::*;

    logic        valid_reg;
    bdc_result_t result_reg;

    assign can_load = !valid_reg || out_ready;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= 1'b0;
        end else if (can_load) begin
            valid_reg <= load;
        end
    end

    always_ff @(posedge aclk) begin
        if (load && can_load) begin
            result_reg <= load_result;
        end
    end

    assign out_valid  = valid_reg;
    assign out_result = result_reg;

endmodule

`default_nettype wire

// File: hdl/button_debounce_click_classifier_unit.sv
// ----------------------------------------------------------------------------
// button_debounce_click_classifier_unit
// Debounces an active-low button sample stream and reports click events.
// ----------------------------------------------------------------------------
// Each request transaction yields exactly one result transaction, passed
// through the input register and then the result register. One transaction is
// accepted every cycle while the result side keeps up; the whole state update
// for a request is a single pass of subtract/compare logic between the two
// registers. Configuration writes take effect on the next cycle.
`default_nettype none

module button_debounce_click_classifier_unit #(
    parameter int TIME_BITS = 32
) (
    input  wire                         aclk,
    input  wire                         aresetn,
    // configuration
    input  wire                         cfg_we,
    input  wire  [bdc_pkg::CFG_A_W-1:0] cfg_addr,
    input  wire  [bdc_pkg::CFG_W-1:0]   cfg_wdata,
    // requests
    input  wire                         s_tvalid,
    output logic                        s_tready,
    input  wire  [39:0]                 s_tdata,  // [31:0] now_ms, [32] raw_level
    input  wire                         s_tuser,  // [0] req_type
    // results
    output logic                        m_tvalid,
    input  wire                         m_tready,
    // [0] short_event, [1] double_event, [2] long_event, [3] poweroff_event,
    // [4] is_pressed, [36:5] held_time, [68:37] activity_time
    output logic [71:0]                 m_tdata
);
    import bdc_pkg::*;

    bdc_cfg_t    cfg;
    bdc_item_t   in_item;
    bdc_item_t   item;
    bdc_result_t core_result;
    bdc_result_t out_result;
    logic        item_valid;
    logic        can_load;
    logic        fire;

    assign in_item.req_type  = s_tuser;
    assign in_item.now_ms    = s_tdata[31:0];
    assign in_item.raw_level = s_tdata[32];

    assign fire = item_valid && can_load;

    bdc_cfg_regs u_cfg (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cfg_we    (cfg_we),
        .cfg_addr  (cfg_addr),
        .cfg_wdata (cfg_wdata),
        .cfg       (cfg)
    );

    bdc_in_stage u_in (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .in_valid   (s_tvalid),
        .in_ready   (s_tready),
        .in_item    (in_item),
        .item_valid (item_valid),
        .item_take  (fire),
        .item       (item)
    );

    bdc_core #(
        .TIME_BITS (TIME_BITS)
    ) u_core (
        .aclk    (aclk),
        .aresetn (aresetn),
        .cfg     (cfg),
        .fire    (fire),
        .item    (item),
        .result  (core_result)
    );

    bdc_out_stage u_out (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .load        (item_valid),
        .load_result (core_result),
        .can_load    (can_load),
        .out_valid   (m_tvalid),
        .out_ready   (m_tready),
        .out_result  (out_result)
    );

    assign m_tdata = {3'b000,
                      out_result.activity_time,
                      out_result.held_time,
                      out_result.is_pressed,
                      out_result.poweroff_event,
                      out_result.long_event,
                      out_result.double_event,
                      out_result.short_event};

endmodule

`default_nettype wire
